/* rtl/core/box_filter_image_downscaler_macros.svh */
// Assertion macros for the checker file of the downscaler.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef BOX_FILTER_IMAGE_DOWNSCALER_MACROS_SVH
`define BOX_FILTER_IMAGE_DOWNSCALER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/bfd_pkg.sv */
// Shared types, constants and functions of the box filter downscaler.
// Depends on nothing.
package bfd_pkg;

  localparam int unsigned SIZE_W = 12;
  localparam int unsigned PIX_W = 8;
  localparam int unsigned SUM_W = 30;
  localparam int unsigned OPP_W = 2 * SIZE_W;
  localparam int unsigned LANES = 4;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 2048;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 12'd256;

  localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH = 3'd0;
  localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_REQUEST_WIDTH = 3'd2;
  localparam logic [IDX_W-1:0] REG_REQUEST_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_ALPHA_MODE = 3'd4;

  // Last step index of the shared block factor divider and of the mean divider.
  localparam logic [CNT_W-1:0] SDIV_LAST = 4'd11;
  localparam logic [CNT_W-1:0] ODIV_LAST = 4'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_LDX,
    ST_SETX,
    ST_LDY,
    ST_SETY,
    ST_MUL
  } ctl_state_e;

  typedef struct packed {
    logic take;
    logic acc;
    logic div_step;
    logic out_load;
    logic sdiv_start;
    logic sdiv_sel;
    logic sdiv_step;
    logic mul;
  } dp_cmd_t;

  typedef struct packed {
    logic cfg_we;
    logic inblock;
    logic emit;
    logic sdiv_last;
    logic div_last;
    logic out_free;
  } dp_sts_t;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int unsigned maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (32'(v) > maxv) begin
      r = SIZE_W'(maxv);
    end
    return r;
  endfunction

endpackage

/* rtl/core/bfd_ctrl.sv */
// Controller state machine of the box filter downscaler.
// Depends on bfd_pkg; drives the datapath through dp_cmd_t.
module bfd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bfd_pkg::dp_sts_t sts_i,
  output bfd_pkg::dp_cmd_t cmd_o,
  output logic             in_stall_o,
  input  logic             in_valid_i
);

  bfd_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    case (state_q)
      bfd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d = bfd_pkg::ST_ACC;
        end
      end
      bfd_pkg::ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d = (sts_i.inblock && sts_i.emit) ? bfd_pkg::ST_DIV : bfd_pkg::ST_IDLE;
      end
      bfd_pkg::ST_DIV: begin
        if (!sts_i.div_last) begin
          cmd_o.div_step = 1'b1;
        end else if (sts_i.out_free) begin
          // The last step writes straight into the output register.
          cmd_o.div_step = 1'b1;
          cmd_o.out_load = 1'b1;
          state_d = bfd_pkg::ST_IDLE;
        end
      end
      bfd_pkg::ST_LDX: begin
        cmd_o.sdiv_start = 1'b1;
        state_d = bfd_pkg::ST_SETX;
      end
      bfd_pkg::ST_SETX: begin
        cmd_o.sdiv_step = 1'b1;
        if (sts_i.sdiv_last) state_d = bfd_pkg::ST_LDY;
      end
      bfd_pkg::ST_LDY: begin
        cmd_o.sdiv_start = 1'b1;
        cmd_o.sdiv_sel = 1'b1;
        state_d = bfd_pkg::ST_SETY;
      end
      bfd_pkg::ST_SETY: begin
        cmd_o.sdiv_step = 1'b1;
        if (sts_i.sdiv_last) state_d = bfd_pkg::ST_MUL;
      end
      bfd_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = bfd_pkg::ST_IDLE;
      end
      default: begin
        state_d = bfd_pkg::ST_IDLE;
      end
    endcase
    // A register write restarts the frame and recomputes the block factors.
    if (sts_i.cfg_we) begin
      state_d = bfd_pkg::ST_LDX;
      cmd_o.take = 1'b0;
      in_stall_o = 1'b1;
    end
  end

endmodule

/* rtl/core/bfd_datapath.sv */
// Datapath of the box filter downscaler: registers, counters, line store, dividers.
// Depends on bfd_pkg; commanded by bfd_ctrl.
module bfd_datapath #(
  parameter int unsigned MAX_WIDTH = bfd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bfd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bfd_pkg::dp_cmd_t              cmd_i,
  output bfd_pkg::dp_sts_t              sts_o,
  input  logic                          cfg_we_i,
  input  logic [bfd_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [bfd_pkg::SIZE_W-1:0]    cfg_data_i,
  input  logic [bfd_pkg::PIX_W-1:0]     red_in_i,
  input  logic [bfd_pkg::PIX_W-1:0]     green_in_i,
  input  logic [bfd_pkg::PIX_W-1:0]     blue_in_i,
  input  logic [bfd_pkg::PIX_W-1:0]     alpha_in_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [bfd_pkg::PIX_W-1:0]     red_out_o,
  output logic [bfd_pkg::PIX_W-1:0]     green_out_o,
  output logic [bfd_pkg::PIX_W-1:0]     blue_out_o,
  output logic [bfd_pkg::PIX_W-1:0]     alpha_out_o,
  output logic                          frame_done_o
);

  localparam int unsigned SW = bfd_pkg::SIZE_W;
  localparam int unsigned PW = bfd_pkg::PIX_W;
  localparam int unsigned UW = bfd_pkg::SUM_W;
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned NL = bfd_pkg::LANES;

  logic [SW-1:0] sw_q, sh_q, rw_q, rh_q;
  logic          am_q;
  logic          cfg_hit;

  always_comb begin
    cfg_hit = 1'b0;
    case (cfg_index_i)
      bfd_pkg::REG_SOURCE_WIDTH, bfd_pkg::REG_SOURCE_HEIGHT,
      bfd_pkg::REG_REQUEST_WIDTH, bfd_pkg::REG_REQUEST_HEIGHT,
      bfd_pkg::REG_ALPHA_MODE: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  wire cfg_we = cfg_we_i && cfg_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= bfd_pkg::SIZE_RESET;
      sh_q <= bfd_pkg::SIZE_RESET;
      rw_q <= bfd_pkg::SIZE_RESET;
      rh_q <= bfd_pkg::SIZE_RESET;
      am_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bfd_pkg::REG_SOURCE_WIDTH:   sw_q <= cfg_data_i;
        bfd_pkg::REG_SOURCE_HEIGHT:  sh_q <= cfg_data_i;
        bfd_pkg::REG_REQUEST_WIDTH:  rw_q <= cfg_data_i;
        bfd_pkg::REG_REQUEST_HEIGHT: rh_q <= cfg_data_i;
        bfd_pkg::REG_ALPHA_MODE:     am_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] swc, shc, rwc, rhc, ow, oh;
  assign swc = bfd_pkg::clamp_size(sw_q, MAX_WIDTH);
  assign shc = bfd_pkg::clamp_size(sh_q, MAX_HEIGHT);
  assign rwc = bfd_pkg::clamp_size(rw_q, MAX_WIDTH);
  assign rhc = bfd_pkg::clamp_size(rh_q, MAX_HEIGHT);
  assign ow = (rwc < swc) ? rwc : swc;
  assign oh = (rhc < shc) ? rhc : shc;

  // Block factor divider: restoring, one quotient bit per cycle.
  logic [SW-1:0] bsx_q, bsy_q;
  logic [bfd_pkg::OPP_W-1:0] opp_q;
  logic [SW:0]   srem_q, srem_t;
  logic [SW-1:0] sn_q, sq_q, sq_d, sdv;
  logic          ssel_q;
  logic [bfd_pkg::CNT_W-1:0] cnt_q;

  assign sdv = ssel_q ? rhc : rwc;
  assign srem_t = {srem_q[SW-1:0], sn_q[SW-1]};
  assign sq_d = {sq_q[SW-2:0], (srem_t >= {1'b0, sdv})};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsx_q <= SW'(1);
      bsy_q <= SW'(1);
      opp_q <= bfd_pkg::OPP_W'(1);
    end else begin
      if (cmd_i.sdiv_step && sts_o.sdiv_last) begin
        if (ssel_q) bsy_q <= (sq_d == '0) ? SW'(1) : sq_d;
        else        bsx_q <= (sq_d == '0) ? SW'(1) : sq_d;
      end
      if (cmd_i.mul) opp_q <= bsx_q * bsy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sdiv_start) begin
      srem_q <= '0;
      sq_q <= '0;
      ssel_q <= cmd_i.sdiv_sel;
      sn_q <= cmd_i.sdiv_sel ? shc : swc;
    end else if (cmd_i.sdiv_step) begin
      srem_q <= (srem_t >= {1'b0, sdv}) ? (srem_t - {1'b0, sdv}) : srem_t;
      sn_q <= {sn_q[SW-2:0], 1'b0};
      sq_q <= sq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.sdiv_start || cmd_i.acc) begin
      cnt_q <= '0;
    end else if (cmd_i.sdiv_step || cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Source position and position within the current block.
  logic [SW-1:0] col_q, row_q, cx_q, cy_q, ocol_q, orow_q;
  logic [SW:0]   col_inc, row_inc;
  assign col_inc = {1'b0, col_q} + 1'b1;
  assign row_inc = {1'b0, row_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; row_q <= '0; cx_q <= '0; cy_q <= '0; ocol_q <= '0; orow_q <= '0;
    end else if (cfg_we) begin
      col_q <= '0; row_q <= '0; cx_q <= '0; cy_q <= '0; ocol_q <= '0; orow_q <= '0;
    end else if (cmd_i.take) begin
      if (col_inc >= {1'b0, swc}) begin
        col_q <= '0;
        cx_q <= '0;
        ocol_q <= '0;
        if (row_inc >= {1'b0, shc}) begin
          row_q <= '0;
          cy_q <= '0;
          orow_q <= '0;
        end else begin
          row_q <= row_inc[SW-1:0];
          if (cy_q == bsy_q - 1'b1) begin
            cy_q <= '0;
            orow_q <= orow_q + 1'b1;
          end else begin
            cy_q <= cy_q + 1'b1;
          end
        end
      end else begin
        col_q <= col_inc[SW-1:0];
        if (cx_q == bsx_q - 1'b1) begin
          cx_q <= '0;
          ocol_q <= ocol_q + 1'b1;
        end else begin
          cx_q <= cx_q + 1'b1;
        end
      end
    end
  end

  // Item latched at accept, with its block flags.
  logic [PW-1:0] pix_q [NL];
  logic [AW-1:0] addr_q;
  logic          fresh_q, inblk_q, emit_q, fdone_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      pix_q[0] <= red_in_i;
      pix_q[1] <= green_in_i;
      pix_q[2] <= blue_in_i;
      pix_q[3] <= alpha_in_i;
      addr_q <= AW'(ocol_q);
      fresh_q <= (cx_q == '0) && (cy_q == '0);
      emit_q <= (cx_q == bsx_q - 1'b1) && (cy_q == bsy_q - 1'b1);
      fdone_q <= (ocol_q == ow - 1'b1) && (orow_q == oh - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inblk_q <= 1'b0;
    end else if (cmd_i.take) begin
      inblk_q <= (ocol_q < ow) && (orow_q < oh);
    end
  end

  // Line store of column sums, four lanes in one word.
  logic [NL*UW-1:0] mem [MAX_WIDTH];
  logic [NL*UW-1:0] rd_q, wr_d;
  logic [UW-1:0]    sum [NL];

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      sum[k] = (fresh_q ? '0 : rd_q[k*UW +: UW]) + UW'(pix_q[k]);
      wr_d[k*UW +: UW] = sum[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) rd_q <= mem[AW'(ocol_q)];
    if (cmd_i.acc && inblk_q) mem[addr_q] <= wr_d;
  end

  // Mean divider: the quotient is below 256, so eight restoring steps suffice.
  logic [UW-1:0] rem_q [NL];
  logic [PW-1:0] quo_q [NL];
  logic [PW-1:0] quo_d [NL];
  logic [UW-1:0] rem_d [NL];
  logic [31:0]   trial;

  always_comb begin
    trial = 32'(opp_q) << (3'd7 - cnt_q[2:0]);
    for (int k = 0; k < NL; k++) begin
      if (32'(rem_q[k]) >= trial) begin
        rem_d[k] = rem_q[k] - UW'(trial);
        quo_d[k] = {quo_q[k][PW-2:0], 1'b1};
      end else begin
        rem_d[k] = rem_q[k];
        quo_d[k] = {quo_q[k][PW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NL; k++) begin
      if (cmd_i.acc) begin
        rem_q[k] <= sum[k];
        quo_q[k] <= '0;
      end else if (cmd_i.div_step) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      red_out_o <= quo_d[0];
      green_out_o <= quo_d[1];
      blue_out_o <= quo_d[2];
      alpha_out_o <= am_q ? quo_d[3] : '0;
      frame_done_o <= fdone_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.cfg_we = cfg_we;
  assign sts_o.inblock = inblk_q;
  assign sts_o.emit = emit_q;
  assign sts_o.sdiv_last = (cnt_q == bfd_pkg::SDIV_LAST);
  assign sts_o.div_last = (cnt_q == bfd_pkg::ODIV_LAST);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

endmodule

/* rtl/core/box_filter_image_downscaler.sv */
// Top level of the box filter image downscaler.
// Depends on bfd_pkg, bfd_ctrl and bfd_datapath.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  red, green, blue, alpha
//   out      output     out_valid_o / out_stall_i  means and frame_done
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// An item that yields no result is done after the read-modify-write of the line store; one that
// closes a block also passes through the eight-step mean divider.
// A register write is followed by a recomputation of the block factors by a bit-serial
// divider and a multiply, during which no item is taken.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled result holds the final divider step until the output register frees.
module box_filter_image_downscaler #(
  parameter int unsigned MAX_WIDTH = bfd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bfd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [bfd_pkg::PIX_W-1:0]  red_in_i,
  input  logic [bfd_pkg::PIX_W-1:0]  green_in_i,
  input  logic [bfd_pkg::PIX_W-1:0]  blue_in_i,
  input  logic [bfd_pkg::PIX_W-1:0]  alpha_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bfd_pkg::PIX_W-1:0]  red_out_o,
  output logic [bfd_pkg::PIX_W-1:0]  green_out_o,
  output logic [bfd_pkg::PIX_W-1:0]  blue_out_o,
  output logic [bfd_pkg::PIX_W-1:0]  alpha_out_o,
  output logic                       frame_done_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bfd_pkg::IDX_W-1:0]  cfg_index_i,
  input  logic [bfd_pkg::SIZE_W-1:0] cfg_data_i
);

  bfd_pkg::dp_cmd_t cmd;
  bfd_pkg::dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  bfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .in_valid_i (in_valid_i)
  );

  bfd_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .alpha_in_i   (alpha_in_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .alpha_out_o  (alpha_out_o),
    .frame_done_o (frame_done_o)
  );

endmodule

/* rtl/core/bfd_checker.sv */
// Port-level checks of the box filter downscaler, bound to the top level.
// Depends on bfd_pkg and box_filter_image_downscaler_macros.svh.
`include "box_filter_image_downscaler_macros.svh"

module bfd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic [bfd_pkg::IDX_W-1:0] cfg_index_i
);

  // A result that is stalled stays offered.
  `BFD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  // Each accepted item is worked on before the next one is taken.
  `BFD_ASSERT_NEXT(a_one_item, in_valid_i && !in_stall_o, in_stall_o)
  // A write to the source width register starts the block factor setup, which takes no item.
  `BFD_ASSERT_NEXT(a_cfg_setup,
    cfg_valid_i && cfg_ready_o && (cfg_index_i == bfd_pkg::REG_SOURCE_WIDTH), in_stall_o)

endmodule

bind box_filter_image_downscaler bfd_checker u_bfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_index_i (cfg_index_i)
);

/* tb/tb_top.sv */
// Self-checking testbench of the box filter image downscaler.
// Depends on bfd_pkg and box_filter_image_downscaler; a local predictor forms each result.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [bfd_pkg::PIX_W-1:0] red;
    logic [bfd_pkg::PIX_W-1:0] green;
    logic [bfd_pkg::PIX_W-1:0] blue;
    logic [bfd_pkg::PIX_W-1:0] alpha;
    logic                      done;
  } mean_pixel_t;

  localparam int MAX_DIM = bfd_pkg::MAX_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 40;
  // Indexes past the register list.
  localparam logic [bfd_pkg::IDX_W-1:0] UNUSED_INDEX_HIGH = 3'd7;
  localparam logic [bfd_pkg::IDX_W-1:0] UNUSED_INDEX_LOW = 3'd5;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [bfd_pkg::PIX_W-1:0] red_in_i, green_in_i, blue_in_i, alpha_in_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [bfd_pkg::PIX_W-1:0] red_out_o, green_out_o, blue_out_o, alpha_out_o;
  logic frame_done_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [bfd_pkg::IDX_W-1:0] cfg_index_i;
  logic [bfd_pkg::SIZE_W-1:0] cfg_data_i;

  box_filter_image_downscaler u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .red_in_i, .green_in_i, .blue_in_i,
    .alpha_in_i, .out_valid_o, .out_stall_i, .red_out_o, .green_out_o, .blue_out_o,
    .alpha_out_o, .frame_done_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Predictor state.
  logic [bfd_pkg::SIZE_W-1:0] src_w, src_h, req_w, req_h;
  logic                       rgba;
  int                         col_pos, row_pos;
  logic [bfd_pkg::SUM_W-1:0]  red_sum [MAX_DIM];
  logic [bfd_pkg::SUM_W-1:0]  green_sum [MAX_DIM];
  logic [bfd_pkg::SUM_W-1:0]  blue_sum [MAX_DIM];
  logic [bfd_pkg::SUM_W-1:0]  alpha_sum [MAX_DIM];

  mean_pixel_t pending_means [$];
  int          error_count = 0;
  int          pixels_sent = 0;
  int          idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
  int          quiet_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int clamp_dim(logic [bfd_pkg::SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  task automatic predict_pixel(input logic [bfd_pkg::PIX_W-1:0] r, g, b, a);
    int sw, sh, rw, rh, ow, oh, bsx, bsy, opp, ocol, orow;
    logic fresh;
    mean_pixel_t m;
    sw = clamp_dim(src_w);
    sh = clamp_dim(src_h);
    rw = clamp_dim(req_w);
    rh = clamp_dim(req_h);
    ow = (rw < sw) ? rw : sw;
    oh = (rh < sh) ? rh : sh;
    bsx = (sw / rw < 1) ? 1 : sw / rw;
    bsy = (sh / rh < 1) ? 1 : sh / rh;
    opp = bsx * bsy;
    if (col_pos >= sw) col_pos = 0;
    if (row_pos >= sh) row_pos = 0;
    ocol = col_pos / bsx;
    orow = row_pos / bsy;
    if (ocol < ow && orow < oh) begin
      fresh = (row_pos % bsy == 0) && (col_pos % bsx == 0);
      red_sum[ocol] = (fresh ? '0 : red_sum[ocol]) + r;
      green_sum[ocol] = (fresh ? '0 : green_sum[ocol]) + g;
      blue_sum[ocol] = (fresh ? '0 : blue_sum[ocol]) + b;
      alpha_sum[ocol] = (fresh ? '0 : alpha_sum[ocol]) + a;
      if (col_pos % bsx == bsx - 1 && row_pos % bsy == bsy - 1) begin
        m.red = bfd_pkg::PIX_W'(red_sum[ocol] / opp);
        m.green = bfd_pkg::PIX_W'(green_sum[ocol] / opp);
        m.blue = bfd_pkg::PIX_W'(blue_sum[ocol] / opp);
        m.alpha = rgba ? bfd_pkg::PIX_W'(alpha_sum[ocol] / opp) : '0;
        m.done = (ocol == ow - 1) && (orow == oh - 1);
        pending_means.push_back(m);
      end
    end
    if (col_pos + 1 >= sw) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= sh) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  function automatic logic sender_idles();
    return (idle_mode == 1 && $urandom_range(99) < 62) ||
           (idle_mode == 3 && $urandom_range(99) < 16);
  endfunction

  always @(negedge clk_i) begin
    if (idle_mode == 2) begin
      out_stall_i <= ($urandom_range(99) < 62);
    end else if (idle_mode == 3) begin
      out_stall_i <= ($urandom_range(99) < 16);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_pixel(input logic [bfd_pkg::PIX_W-1:0] r, g, b, a);
    logic taken;
    @(negedge clk_i);
    while (sender_idles()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_in_i <= r;
    green_in_i <= g;
    blue_in_i <= b;
    alpha_in_i <= a;
    taken = 1'b0;
    while (!taken) begin
      #1 taken = !in_stall_o;
      @(posedge clk_i);
      if (!taken) @(negedge clk_i);
    end
    predict_pixel(r, g, b, a);
    pixels_sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic send_random_pixels(input int count);
    repeat (count) begin
      send_pixel(bfd_pkg::PIX_W'($urandom), bfd_pkg::PIX_W'($urandom),
                 bfd_pkg::PIX_W'($urandom), bfd_pkg::PIX_W'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bfd_pkg::IDX_W-1:0] idx,
                           input logic [bfd_pkg::SIZE_W-1:0] data);
    logic taken;
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    taken = 1'b0;
    while (!taken) begin
      #1 taken = cfg_ready_o;
      @(posedge clk_i);
      if (!taken) @(negedge clk_i);
    end
    case (idx)
      bfd_pkg::REG_SOURCE_WIDTH: src_w = data;
      bfd_pkg::REG_SOURCE_HEIGHT: src_h = data;
      bfd_pkg::REG_REQUEST_WIDTH: req_w = data;
      bfd_pkg::REG_REQUEST_HEIGHT: req_h = data;
      bfd_pkg::REG_ALPHA_MODE: rgba = data[0];
      default: ;
    endcase
    if (idx <= bfd_pkg::REG_ALPHA_MODE) begin
      col_pos = 0;
      row_pos = 0;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_geometry(input logic [bfd_pkg::SIZE_W-1:0] sw, sh, rw, rh,
                              input logic am);
    write_reg(bfd_pkg::REG_SOURCE_WIDTH, sw);
    write_reg(bfd_pkg::REG_SOURCE_HEIGHT, sh);
    write_reg(bfd_pkg::REG_REQUEST_WIDTH, rw);
    write_reg(bfd_pkg::REG_REQUEST_HEIGHT, rh);
    write_reg(bfd_pkg::REG_ALPHA_MODE, bfd_pkg::SIZE_W'(am));
  endtask

  always @(posedge clk_i) begin
    mean_pixel_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_means.size() == 0) begin
        $display("%0t: result with none expected: %h %h %h %h %b", $time, red_out_o,
                 green_out_o, blue_out_o, alpha_out_o, frame_done_o);
        error_count++;
      end else begin
        want = pending_means.pop_front();
        if (want.red !== red_out_o) begin
          $display("%0t: red expected %h actual %h", $time, want.red, red_out_o);
          error_count++;
        end
        if (want.green !== green_out_o) begin
          $display("%0t: green expected %h actual %h", $time, want.green, green_out_o);
          error_count++;
        end
        if (want.blue !== blue_out_o) begin
          $display("%0t: blue expected %h actual %h", $time, want.blue, blue_out_o);
          error_count++;
        end
        if (want.alpha !== alpha_out_o) begin
          $display("%0t: alpha expected %h actual %h", $time, want.alpha, alpha_out_o);
          error_count++;
        end
        if (want.done !== frame_done_o) begin
          $display("%0t: frame_done expected %b actual %b", $time, want.done, frame_done_o);
          error_count++;
        end
      end
    end
  end

  // Any accepted item on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_reset_passthrough();
    // Reset geometry is 256 by 256 with no scaling, so every item is echoed with alpha zero.
    send_pixel(8'h00, 8'hff, 8'h00, 8'hff);
    send_pixel(8'hff, 8'h00, 8'hff, 8'h00);
    send_random_pixels(4);
  endtask

  task automatic test_extremes();
    // Two blocks of 3 by 3 fed nine full-scale items and then nine zero items, in RGBA mode.
    set_geometry(12'd6, 12'd3, 12'd2, 12'd1, 1'b1);
    repeat (9) send_pixel(8'hff, 8'hff, 8'hff, 8'hff);
    repeat (9) send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    // Zero sizes act as one; the single pixel closes the frame.
    set_geometry(12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    send_random_pixels(2);
    // Oversized sizes clamp to the maximum; a pass-through row.
    set_geometry(12'hfff, 12'd1, 12'hfff, 12'd1, 1'b1);
    send_random_pixels(4);
    // Leftover column and row beyond the whole blocks are dropped.
    set_geometry(12'd5, 12'd5, 12'd2, 12'd2, 1'b0);
    send_random_pixels(25);
    // Writes to unused indexes must leave the frame position alone.
    write_reg(UNUSED_INDEX_HIGH, 12'hfff);
    write_reg(UNUSED_INDEX_LOW, 12'h000);
    send_random_pixels(6);
    // Request larger than the source is clamped to the source.
    set_geometry(12'd3, 12'd2, 12'd9, 12'd9, 1'b1);
    send_random_pixels(8);
  endtask

  task automatic test_random_frames();
    int phase;
    int sw, sh;
    phase = 0;
    while (pixels_sent < 1500) begin
      idle_mode = phase % 4;
      sw = $urandom_range(1, 12);
      sh = $urandom_range(1, 8);
      set_geometry(bfd_pkg::SIZE_W'(sw), bfd_pkg::SIZE_W'(sh),
                   bfd_pkg::SIZE_W'($urandom_range(1, sw + 1)),
                   bfd_pkg::SIZE_W'($urandom_range(1, sh + 1)), 1'($urandom));
      send_random_pixels(sw * sh * $urandom_range(1, 3) + $urandom_range(0, sw));
      if (phase % 7 == 3) begin
        while (pending_means.size() != 0) @(posedge clk_i);
      end
      phase++;
    end
    idle_mode = 0;
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    red_in_i = '0;
    green_in_i = '0;
    blue_in_i = '0;
    alpha_in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    src_w = bfd_pkg::SIZE_RESET;
    src_h = bfd_pkg::SIZE_RESET;
    req_w = bfd_pkg::SIZE_RESET;
    req_h = bfd_pkg::SIZE_RESET;
    rgba = 1'b0;
    col_pos = 0;
    row_pos = 0;
    for (int i = 0; i < MAX_DIM; i++) begin
      red_sum[i] = '0;
      green_sum[i] = '0;
      blue_sum[i] = '0;
      alpha_sum[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_passthrough();
    test_extremes();
    test_random_frames();
    wait_drained();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
